// ===== hdl/local_mean_threshold_3x3_macros.svh =====
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3_macros: assertion helpers
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LOCAL_MEAN_THRESHOLD_3X3_MACROS_SVH
`define LOCAL_MEAN_THRESHOLD_3X3_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define LMT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LMT_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define LMT_ASSERT_IMP(name, ante, cons, msg)
`define LMT_ASSERT_NXT(name, ante, cons, msg)

`endif

`endif

// ===== hdl/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants
// Field widths, register codes and the threshold test of the 3x3 binarizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lmt_pkg;

  localparam int PIX_W         = 8;
  localparam int ROW_W         = 16;
  localparam int CFG_W_W       = 11;   // image_width register
  localparam int CFG_H_W       = 16;   // image_height register
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int WINDOW        = 3;
  localparam int NCELL         = WINDOW - 1;  // stored columns; third is the new one
  localparam int SUM_W         = 10;          // 3-pixel column sum, max 765
  localparam int WSUM_W        = 12;          // 9-pixel window sum, max 2295
  localparam int MAX_RES       = 4;           // results per input beat
  localparam int RES_N_W       = 3;
  localparam int QDEPTH        = 8;           // output queue entries, power of two

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 16'd480;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // One window column, for the upper output row (0) and the lower one (1)
  typedef struct packed {
    logic [SUM_W-1:0] sum0;
    logic [SUM_W-1:0] sum1;
    logic [PIX_W-1:0] cen0;
    logic [PIX_W-1:0] cen1;
  } lmt_col_t;

  // Line store word: two rows of one column
  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] prev;
  } lmt_line_t;

  // 1 when nine times the centre exceeds the window sum
  function automatic logic judge(input logic [WSUM_W-1:0] wsum,
                                 input logic [PIX_W-1:0] cen);
    logic [WSUM_W-1:0] nine;
    nine = WSUM_W'({cen, 3'b000}) + WSUM_W'(cen);
    return nine > wsum;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lmt_linebuf.sv =====
// ----------------------------------------------------------------------------
// lmt_linebuf: two-row line store
// One write and one registered read per cycle; a read sees the old word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmt_linebuf
  import lmt_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_WIDTH
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output lmt_line_t                     rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire lmt_line_t                wr_data
);

  lmt_line_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lmt_cell.sv =====
// ----------------------------------------------------------------------------
// lmt_cell: one window column
// Holds column sums and centres of both output rows; loads from its neighbor or, at the head, from the new column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmt_cell
  import lmt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     clr,
  input  wire logic     shift,
  input  wire lmt_col_t d,
  output lmt_col_t      q
);

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lmt_outq.sv =====
// ----------------------------------------------------------------------------
// lmt_outq: result queue
// Takes up to four entries a cycle, gives one a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lmt_outq
  import lmt_pkg::*;
#(
  parameter int DATA_W = 29
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [RES_N_W-1:0]            push_n,
  input  wire logic [DATA_W-1:0]             push_data [MAX_RES],
  input  wire logic                          pop,
  output logic                               not_empty,
  output logic [DATA_W-1:0]                  head,
  output logic [$clog2(QDEPTH+1)-1:0]        count
);

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [DATA_W-1:0] mem [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic              do_pop;

  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_n);
      rd_ptr <= rd_ptr + PW'(do_pop);
      count  <= count + CW'(push_n) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (i < int'(push_n)) begin
        mem[wr_ptr + PW'(i)] <= push_data[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/local_mean_threshold_3x3.sv =====
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3: 3x3 local-mean binarizer
// Raster pixels in, one binary result per pixel out, tagged with row/column.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat                      fields (low bit first)
//  s_axis   in   one pixel                 tdata: pixel[7:0]
//  m_axis   out  one result                tdata: out_row, out_col, binary
//                                          tlast: run_last  tuser: frame_last
//  cfg      in   one register write        cfg_index, cfg_data
//
//  Cycles: a pixel is taken every clock while the result queue has room.
//  Each pixel makes at most one result mid-row and two at a row end (two and
//  four on the last row), and m_axis moves one result a clock, so the output
//  port sets the sustained rate: one pixel a clock on most rows, less on the
//  last row. Reset: synchronous; registers return to 640 x 480 and the
//  frame restarts at (0, 0); line stores are not cleared. Stalls on m_axis
//  back up through the eight-entry queue to s_axis tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "local_mean_threshold_3x3_macros.svh"

module local_mean_threshold_3x3
  import lmt_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // pixel stream
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [PIX_W-1:0]        s_axis_tdata,   // pixel[7:0]
  // result stream
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // out_row[15:0], out_col[16 +: COL_W], binary, zero fill
  output logic [((ROW_W + $clog2(MAX_WIDTH) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                         m_axis_tlast,   // run_last
  output logic                         m_axis_tuser,   // frame_last
  // configuration
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int OUT_DATA_W = ((ROW_W + COL_W + 1 + 7) / 8) * 8;
  localparam int ENT_W      = ROW_W + COL_W + 3;  // {frame_last, run_last, binary, col, row}
  localparam int QCW        = $clog2(QDEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration and frame position
  // --------------------------------------------------------------------------
  logic [CFG_W_W-1:0] image_width;
  logic [CFG_H_W-1:0] image_height;
  logic [COL_W-1:0]   w_last;        // effective width - 1
  logic [ROW_W-1:0]   h_last;        // effective height - 1
  logic [COL_W-1:0]   col_count;
  logic [ROW_W-1:0]   row_count;
  logic               accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[CFG_W_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate to 2..MAX_WIDTH and 2..
  always_comb begin
    if (image_width < 11'd2) begin
      w_last = COL_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'(image_width - 11'd1);
    end
    if (image_height < 16'd2) begin
      h_last = ROW_W'(1);
    end else begin
      h_last = image_height - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count == w_last) begin
        col_count <= '0;
        row_count <= (row_count == h_last) ? '0 : row_count + 16'd1;
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: take the pixel, read the line store, work out which results
  // --------------------------------------------------------------------------
  logic               emit_a;     // result for column c-1
  logic               emit_e;     // extra result for the last column
  logic               last_row;
  logic [RES_N_W-1:0] res_n;

  logic               s1_valid;
  logic [PIX_W-1:0]   s1_px;
  logic [COL_W-1:0]   s1_c;
  logic [ROW_W-1:0]   s1_r;
  logic               s1_use_prev;   // rows 0 and 1: row above clamps
  logic               s1_col_one;    // left neighbor reflects
  logic               s1_edge;
  logic [RES_N_W-1:0] s1_n;

  logic [QCW-1:0]     q_count;

  assign last_row = (row_count == h_last);
  assign emit_a   = (row_count != '0) && (col_count != '0);
  assign emit_e   = (row_count != '0) && (col_count == w_last);

  always_comb begin
    if (!emit_a) begin
      res_n = RES_N_W'(0);
    end else if (emit_e) begin
      res_n = last_row ? RES_N_W'(4) : RES_N_W'(2);
    end else begin
      res_n = last_row ? RES_N_W'(2) : RES_N_W'(1);
    end
  end

  // room for the beat in stage 1 plus a full set from this one
  assign s_axis_tready = (int'(q_count) + int'(s1_n)) <= (QDEPTH - MAX_RES);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_n     <= '0;
    end else begin
      s1_valid <= accept;
      s1_n     <= accept ? res_n : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px       <= s_axis_tdata;
      s1_c        <= col_count;
      s1_r        <= row_count;
      s1_use_prev <= (row_count <= 16'd1);
      s1_col_one  <= (col_count == COL_W'(1));
      s1_edge     <= emit_e;
    end
  end

  lmt_line_t line_rd;
  lmt_line_t line_wr;
  logic [PIX_W-1:0] b_pix;
  logic [PIX_W-1:0] a_pix;

  assign b_pix         = line_rd.prev;
  assign a_pix         = s1_use_prev ? b_pix : line_rd.older;
  assign line_wr.older = b_pix;
  assign line_wr.prev  = s1_px;

  lmt_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (line_rd),
    .wr_en   (s1_valid),
    .wr_addr (s1_c),
    .wr_data (line_wr)
  );

  // --------------------------------------------------------------------------
  // Stage 2: new column enters the cell chain; window tests into the queue
  // --------------------------------------------------------------------------
  lmt_col_t new_col;
  lmt_col_t cell_d [NCELL];
  lmt_col_t cell_q [NCELL];

  assign new_col.sum0 = SUM_W'(a_pix) + SUM_W'(b_pix) + SUM_W'(s1_px);
  assign new_col.sum1 = SUM_W'(b_pix) + SUM_W'({s1_px, 1'b0});  // bottom clamps
  assign new_col.cen0 = b_pix;
  assign new_col.cen1 = s1_px;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == NCELL - 1) begin : g_head
      assign cell_d[k] = new_col;
    end else begin : g_link
      assign cell_d[k] = cell_q[k+1];
    end
    lmt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .clr   (cfg_we),
      .shift (s1_valid),
      .d     (cell_d[k]),
      .q     (cell_q[k])
    );
  end

  // window before the shift: left = cell 0, middle = cell 1, right = new column
  logic [SUM_W-1:0]  left0, left1;
  logic [WSUM_W-1:0] wa0, we0, wa1, we1;
  logic              bin_a0, bin_e0, bin_a1, bin_e1;

  assign left0 = s1_col_one ? new_col.sum0 : cell_q[0].sum0;
  assign left1 = s1_col_one ? new_col.sum1 : cell_q[0].sum1;
  assign wa0 = WSUM_W'(left0) + WSUM_W'(cell_q[1].sum0) + WSUM_W'(new_col.sum0);
  assign wa1 = WSUM_W'(left1) + WSUM_W'(cell_q[1].sum1) + WSUM_W'(new_col.sum1);
  // right edge reflects: left column (cell 1) counted twice
  assign we0 = WSUM_W'({cell_q[1].sum0, 1'b0}) + WSUM_W'(new_col.sum0);
  assign we1 = WSUM_W'({cell_q[1].sum1, 1'b0}) + WSUM_W'(new_col.sum1);

  assign bin_a0 = judge(wa0, cell_q[1].cen0);
  assign bin_e0 = judge(we0, new_col.cen0);
  assign bin_a1 = judge(wa1, cell_q[1].cen1);
  assign bin_e1 = judge(we1, new_col.cen1);

  logic [ROW_W-1:0]   row_up;
  logic [COL_W-1:0]   col_left;
  logic [ENT_W-1:0]   slot [MAX_RES];
  logic [RES_N_W-1:0] push_n;

  assign row_up   = s1_r - 16'd1;
  assign col_left = s1_c - COL_W'(1);

  // order: upper row mid, upper row edge, lower row mid, lower row edge; with no edge, slot 1 is lower row mid
  always_comb begin
    slot[0] = {1'b0, 1'b0, bin_a0, col_left, row_up};
    if (s1_edge) begin
      slot[1] = {1'b0, 1'b0, bin_e0, s1_c, row_up};
    end else begin
      slot[1] = {1'b0, 1'b0, bin_a1, col_left, s1_r};
    end
    slot[2] = {1'b0, 1'b0, bin_a1, col_left, s1_r};
    slot[3] = {1'b1, 1'b0, bin_e1, s1_c, s1_r};
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_N_W'(i + 1) == s1_n) begin
        slot[i][ENT_W-2] = 1'b1;
      end
    end
  end

  assign push_n = s1_valid ? s1_n : '0;

  // --------------------------------------------------------------------------
  // Output queue
  // --------------------------------------------------------------------------
  logic [ENT_W-1:0] q_head;

  lmt_outq #(
    .DATA_W (ENT_W)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .push_data (slot),
    .pop       (m_axis_tready),
    .not_empty (m_axis_tvalid),
    .head      (q_head),
    .count     (q_count)
  );

  assign m_axis_tdata = OUT_DATA_W'(q_head[ROW_W+COL_W:0]);
  assign m_axis_tlast = q_head[ENT_W-2];
  assign m_axis_tuser = q_head[ENT_W-1];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LMT_ASSERT_IMP(a_queue_bound, 1'b1, int'(q_count) <= QDEPTH, "result queue overflow")
  `LMT_ASSERT_IMP(a_frame_end_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end not run end")
  `LMT_ASSERT_NXT(a_cfg_restart, cfg_we, (col_count == '0) && (row_count == '0), "no restart on write")
  `LMT_ASSERT_NXT(a_frame_wrap, accept && (col_count == w_last) && (row_count == h_last), (col_count == '0) && (row_count == '0) && (s1_n == RES_N_W'(4)), "bad frame wrap")

endmodule

`default_nettype wire
